@@ rtl/core/fogs_pkg.sv @@
// shared types and constants of the flash operation gap scheduler
`timescale 1ns / 1ps
package fogs_pkg;

	// defaults of the top level parameters
	localparam int DEF_QUEUE_DEPTH     = 6;
	localparam int DEF_MAX_WRITE_BYTES = 256;

	// configuration registers
	localparam int CFG_DATA_W  = 20;
	localparam int CFG_INDEX_W = 2;
	localparam logic [CFG_INDEX_W-1:0] CFG_ERASE_GUARD = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_WRITE_BASE  = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_BURST_TIME  = 2'd2;

	localparam int ERASE_GUARD_W = 20;
	localparam int WRITE_BASE_W  = 16;
	localparam int BURST_TIME_W  = 10;
	localparam logic [ERASE_GUARD_W-1:0] ERASE_GUARD_RST = 20'd21700;
	localparam logic [WRITE_BASE_W-1:0]  WRITE_BASE_RST  = 16'd400;
	localparam logic [BURST_TIME_W-1:0]  BURST_TIME_RST  = 10'd107;

	// field widths
	localparam int MODE_W  = 2;
	localparam int PAGE_W  = 16;
	localparam int ADDR_W  = 32;
	localparam int LENIN_W = 16;
	localparam int TAG_W   = 8;
	localparam int GAP_W   = 32;
	localparam int KIND_W  = 3;
	localparam int COUNT_W = 5;

	// ticks to microseconds: gap * 625 >> 8
	localparam int GAP_SCALE   = 625;
	localparam int GAP_SHIFT   = 8;
	localparam int GAP_SCALE_W = 10;
	localparam int GAP_PROD_W  = GAP_W + GAP_SCALE_W;
	localparam int GAP_US_W    = GAP_PROD_W - GAP_SHIFT;

	localparam int BURST_BYTES = 16;
	localparam int BURST_SHIFT = 4;
	localparam int WORD_BYTES  = 4;

	typedef enum logic [MODE_W-1:0] {
		MODE_ERASE = 2'd0,
		MODE_WRITE = 2'd1,
		MODE_TICK  = 2'd2
	} mode_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_QUEUE = 3'd0,
		KIND_ERASE = 3'd1,
		KIND_BURST = 3'd2,
		KIND_WORD  = 3'd3,
		KIND_DONE  = 3'd4
	} kind_t;

	typedef struct packed {
		logic [MODE_W-1:0]  mode;
		logic [PAGE_W-1:0]  page_number;
		logic [ADDR_W-1:0]  flash_address;
		logic [ADDR_W-1:0]  source_address;
		logic [LENIN_W-1:0] write_length;
		logic [TAG_W-1:0]   request_tag;
		logic [GAP_W-1:0]   gap_ticks;
		logic               flash_idle;
	} req_word_t;

	typedef struct packed {
		logic [KIND_W-1:0]  result_kind;
		logic               accepted;
		logic [PAGE_W-1:0]  erase_page;
		logic [ADDR_W-1:0]  target_address;
		logic [ADDR_W-1:0]  data_address;
		logic [COUNT_W-1:0] byte_count;
		logic [TAG_W-1:0]   done_tag;
		logic               last;
	} rsp_word_t;

	// controller to datapath
	typedef struct packed {
		logic  push;
		logic  rd_head;
		logic  load_guard;
		logic  step_walk;
		logic  pop;
		logic  out_load;
		kind_t out_kind;
		logic  out_last;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic queue_empty;
		logic is_write;
		logic gap_ok;
		logic walk_more;
		logic out_free;
	} dp_stat_t;

endpackage

@@ rtl/core/fogs_if.sv @@
// request and result channel interfaces
`timescale 1ns / 1ps
interface fogs_req_if;
	import fogs_pkg::*;
	logic               valid;
	logic               ready;
	logic [MODE_W-1:0]  mode;
	logic [PAGE_W-1:0]  page_number;
	logic [ADDR_W-1:0]  flash_address;
	logic [ADDR_W-1:0]  source_address;
	logic [LENIN_W-1:0] write_length;
	logic [TAG_W-1:0]   request_tag;
	logic [GAP_W-1:0]   gap_ticks;
	logic               flash_idle;

	modport source (output valid, mode, page_number, flash_address, source_address,
		write_length, request_tag, gap_ticks, flash_idle, input ready);
	modport sink (input valid, mode, page_number, flash_address, source_address,
		write_length, request_tag, gap_ticks, flash_idle, output ready);
endinterface

interface fogs_rsp_if;
	import fogs_pkg::*;
	logic               valid;
	logic               ready;
	logic [KIND_W-1:0]  result_kind;
	logic               accepted;
	logic [PAGE_W-1:0]  erase_page;
	logic [ADDR_W-1:0]  target_address;
	logic [ADDR_W-1:0]  data_address;
	logic [COUNT_W-1:0] byte_count;
	logic [TAG_W-1:0]   done_tag;
	logic               last;

	modport source (output valid, result_kind, accepted, erase_page, target_address,
		data_address, byte_count, done_tag, last, input ready);
	modport sink (input valid, result_kind, accepted, erase_page, target_address,
		data_address, byte_count, done_tag, last, output ready);
endinterface

@@ rtl/core/fogs_ctrl.sv @@
// sequencing state machine of the gap scheduler
`timescale 1ns / 1ps
module fogs_ctrl
	import fogs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic [MODE_W-1:0] req_mode,
	output logic              req_ready,
	input  dp_stat_t          stat,
	output dp_cmd_t           cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ANSWER,
		ST_GUARD,
		ST_CHECK,
		ST_EMIT,
		ST_DONE
	} state_t;

	state_t state_q, state_d;
	logic   take;

	assign req_ready = (state_q == ST_IDLE);
	assign take      = req_valid && req_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.out_kind = KIND_QUEUE;
		unique case (state_q)
			ST_IDLE: begin
				if (take) begin
					if (req_mode == MODE_ERASE || req_mode == MODE_WRITE) begin
						cmd.push = 1'b1;
						state_d  = ST_ANSWER;
					end else if (req_mode == MODE_TICK && !stat.queue_empty) begin
						cmd.rd_head = 1'b1;
						state_d     = ST_GUARD;
					end
				end
			end
			ST_ANSWER: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_kind = KIND_QUEUE;
					cmd.out_last = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			ST_GUARD: begin
				cmd.load_guard = 1'b1;
				state_d        = ST_CHECK;
			end
			ST_CHECK: begin
				state_d = stat.gap_ok ? ST_EMIT : ST_IDLE;
			end
			ST_EMIT: begin
				if (!stat.is_write) begin
					if (stat.out_free) begin
						cmd.out_load = 1'b1;
						cmd.out_kind = KIND_ERASE;
						state_d      = ST_DONE;
					end
				end else if (!stat.walk_more) begin
					state_d = ST_DONE;
				end else if (stat.out_free) begin
					// datapath picks burst or word from the remaining length
					cmd.out_load  = 1'b1;
					cmd.out_kind  = KIND_BURST;
					cmd.step_walk = 1'b1;
				end
			end
			ST_DONE: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_kind = KIND_DONE;
					cmd.out_last = 1'b1;
					cmd.pop      = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ rtl/core/fogs_dp.sv @@
// request queue, guard arithmetic, write splitter and result register
`timescale 1ns / 1ps
module fogs_dp
	import fogs_pkg::*;
#(
	parameter int QUEUE_DEPTH     = DEF_QUEUE_DEPTH,
	parameter int MAX_WRITE_BYTES = DEF_MAX_WRITE_BYTES
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  req_word_t              req_word,
	output rsp_word_t              rsp_word,
	output logic                   rsp_valid,
	input  logic                   rsp_ready,
	input  dp_cmd_t                cmd,
	output dp_stat_t               stat
);

	localparam int IDX_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
	localparam int SUM_W   = CNT_W + 1;
	localparam int LEN_W   = $clog2(MAX_WRITE_BYTES + 1);
	localparam int POS_W   = LEN_W + 5;
	localparam int PROD_W  = LEN_W + BURST_TIME_W;
	localparam int GUARD_W = (PROD_W + 1 > ERASE_GUARD_W) ? PROD_W + 1 : ERASE_GUARD_W;

	typedef struct packed {
		logic              is_write;
		logic [PAGE_W-1:0] page;
		logic [ADDR_W-1:0] flash_address;
		logic [ADDR_W-1:0] source_address;
		logic [LEN_W-1:0]  length;
		logic [TAG_W-1:0]  tag;
	} slot_t;

	slot_t slot_mem [QUEUE_DEPTH];
	slot_t slot_rd_q;

	logic [ERASE_GUARD_W-1:0] erase_guard_q;
	logic [WRITE_BASE_W-1:0]  write_base_q;
	logic [BURST_TIME_W-1:0]  burst_time_q;

	logic [IDX_W-1:0] head_q;
	logic [CNT_W-1:0] count_q;
	logic [SUM_W-1:0] tail_sum;
	logic [IDX_W-1:0] tail;
	logic             req_ok;
	logic             ok_q;

	logic [GAP_PROD_W-1:0] gap_prod_q;
	logic                  flash_idle_q;
	logic [GUARD_W-1:0]    guard_q;
	logic [PROD_W-1:0]     wr_prod;
	logic [GAP_US_W-1:0]   gap_us;

	logic [POS_W-1:0]   pos_q;
	logic [POS_W-1:0]   len_ext;
	logic [ADDR_W-1:0]  tgt_q;
	logic [ADDR_W-1:0]  src_q;
	logic               is_burst;
	logic [COUNT_W-1:0] word_cnt;

	logic      out_valid_q;
	rsp_word_t out_q;
	rsp_word_t out_d;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			erase_guard_q <= ERASE_GUARD_RST;
			write_base_q  <= WRITE_BASE_RST;
			burst_time_q  <= BURST_TIME_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ERASE_GUARD: erase_guard_q <= cfg_data[ERASE_GUARD_W-1:0];
				CFG_WRITE_BASE:  write_base_q  <= cfg_data[WRITE_BASE_W-1:0];
				CFG_BURST_TIME:  burst_time_q  <= cfg_data[BURST_TIME_W-1:0];
				default: ;
			endcase
		end
	end

	// queue bookkeeping
	assign tail_sum = SUM_W'(head_q) + SUM_W'(count_q);
	assign tail     = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ?
		IDX_W'(tail_sum - SUM_W'(QUEUE_DEPTH)) : IDX_W'(tail_sum);
	assign req_ok   = (count_q < CNT_W'(QUEUE_DEPTH)) &&
		!(req_word.mode == MODE_WRITE &&
		  req_word.write_length > LENIN_W'(MAX_WRITE_BYTES));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else begin
			if (cmd.push && req_ok) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cmd.pop) begin
				count_q <= count_q - CNT_W'(1);
				head_q  <= (head_q == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push && req_ok) begin
			slot_mem[tail] <= '{
				is_write:       (req_word.mode == MODE_WRITE),
				page:           req_word.page_number,
				flash_address:  req_word.flash_address,
				source_address: req_word.source_address,
				length:         LEN_W'(req_word.write_length),
				tag:            req_word.request_tag
			};
		end
		if (cmd.rd_head) begin
			slot_rd_q <= slot_mem[head_q];
		end
	end

	// guard arithmetic and write walk
	assign wr_prod = PROD_W'(slot_rd_q.length >> BURST_SHIFT) * PROD_W'(burst_time_q);
	assign gap_us  = gap_prod_q[GAP_PROD_W-1:GAP_SHIFT];

	assign len_ext  = POS_W'(slot_rd_q.length);
	assign is_burst = len_ext > (pos_q + POS_W'(BURST_BYTES));
	assign word_cnt = ((pos_q + POS_W'(WORD_BYTES)) < len_ext) ?
		COUNT_W'(WORD_BYTES) : COUNT_W'(len_ext - pos_q);

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			ok_q <= req_ok;
		end
		if (cmd.rd_head) begin
			gap_prod_q   <= GAP_PROD_W'(req_word.gap_ticks) * GAP_PROD_W'(GAP_SCALE);
			flash_idle_q <= req_word.flash_idle;
		end
		if (cmd.load_guard) begin
			guard_q <= slot_rd_q.is_write ?
				GUARD_W'(wr_prod) + GUARD_W'(write_base_q) : GUARD_W'(erase_guard_q);
			pos_q   <= '0;
			tgt_q   <= slot_rd_q.flash_address;
			src_q   <= slot_rd_q.source_address;
		end else if (cmd.step_walk) begin
			if (is_burst) begin
				pos_q <= pos_q + POS_W'(BURST_BYTES);
				tgt_q <= tgt_q + ADDR_W'(BURST_BYTES);
				src_q <= src_q + ADDR_W'(BURST_BYTES);
			end else begin
				pos_q <= pos_q + POS_W'(WORD_BYTES);
				tgt_q <= tgt_q + ADDR_W'(WORD_BYTES);
				src_q <= src_q + ADDR_W'(WORD_BYTES);
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// next result word, fields that do not apply stay zero
	always_comb begin
		out_d      = '0;
		out_d.last = cmd.out_last;
		unique case (cmd.out_kind)
			KIND_QUEUE: begin
				out_d.result_kind = KIND_QUEUE;
				out_d.accepted    = ok_q;
			end
			KIND_ERASE: begin
				out_d.result_kind = KIND_ERASE;
				out_d.erase_page  = slot_rd_q.page;
			end
			KIND_BURST, KIND_WORD: begin
				out_d.result_kind    = is_burst ? KIND_BURST : KIND_WORD;
				out_d.target_address = tgt_q;
				out_d.data_address   = src_q;
				out_d.byte_count     = is_burst ? COUNT_W'(BURST_BYTES) : word_cnt;
			end
			KIND_DONE: begin
				out_d.result_kind = KIND_DONE;
				out_d.done_tag    = slot_rd_q.tag;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q <= out_d;
		end
	end

	assign rsp_word  = out_q;
	assign rsp_valid = out_valid_q;

	assign stat.queue_empty = (count_q == '0);
	assign stat.is_write    = slot_rd_q.is_write;
	assign stat.gap_ok      = (gap_us > GAP_US_W'(guard_q)) && flash_idle_q;
	assign stat.walk_more   = pos_q < len_ext;
	assign stat.out_free    = !out_valid_q || rsp_ready;

endmodule

@@ rtl/core/flash_op_gap_scheduler.sv @@
// top level of the flash operation gap scheduler
// usage:
//   req channel: one word is a queue request (erase or write) or a tick that
//     carries the radio-free gap length and the flash idle flag
//   rsp channel: a queue answer for every request; for a tick whose head
//     request fits its gap, the flash commands and then a done word
//   cfg port: erase guard, write guard base and per-burst time, written idle
// timing:
//   one word at a time; req.ready is high only while the sequencer is idle
//   request: queued when taken; its answer is loaded once the result register is free
//   tick: head read, guard load and compare, then one result word per cycle while
//     the result register is free, plus an empty step before a write's done word
//   worst item: a 256-byte write gives 15 bursts, 4 words and done
//   a tick on an empty queue is dropped at once, an unmet guard after the compare
// reset: queue empties, guard registers take their defaults, no result held
// stall: the result register holds its word while rsp.ready is low and the
//   sequencer waits; nothing is dropped
`timescale 1ns / 1ps
module flash_op_gap_scheduler
	import fogs_pkg::*;
#(
	parameter int QUEUE_DEPTH     = DEF_QUEUE_DEPTH,
	parameter int MAX_WRITE_BYTES = DEF_MAX_WRITE_BYTES
) (
	input  logic                   clk,
	input  logic                   arst_n,
	fogs_req_if.sink               req,
	fogs_rsp_if.source             rsp,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	req_word_t req_word;
	rsp_word_t rsp_word;
	dp_cmd_t   cmd;
	dp_stat_t  stat;

	// pack the request word for the datapath
	assign req_word = '{
		mode:           req.mode,
		page_number:    req.page_number,
		flash_address:  req.flash_address,
		source_address: req.source_address,
		write_length:   req.write_length,
		request_tag:    req.request_tag,
		gap_ticks:      req.gap_ticks,
		flash_idle:     req.flash_idle
	};

	// sequencer: decides which step runs and which result word is loaded
	fogs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_mode  (req.mode),
		.req_ready (req.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// queue memory, guard math, write splitter and the result register
	fogs_dp #(
		.QUEUE_DEPTH     (QUEUE_DEPTH),
		.MAX_WRITE_BYTES (MAX_WRITE_BYTES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_word  (req_word),
		.rsp_word  (rsp_word),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	// unpack the result word onto the channel
	assign rsp.result_kind    = rsp_word.result_kind;
	assign rsp.accepted       = rsp_word.accepted;
	assign rsp.erase_page     = rsp_word.erase_page;
	assign rsp.target_address = rsp_word.target_address;
	assign rsp.data_address   = rsp_word.data_address;
	assign rsp.byte_count     = rsp_word.byte_count;
	assign rsp.done_tag       = rsp_word.done_tag;
	assign rsp.last           = rsp_word.last;

endmodule

@@ bench/tb_top.sv @@
// self-checking bench for the flash operation gap scheduler: directed table, then random phases
`timescale 1ns / 1ps
module tb_top;
	import fogs_pkg::*;

	localparam int QUEUE_DEPTH     = DEF_QUEUE_DEPTH;
	localparam int MAX_WRITE_BYTES = DEF_MAX_WRITE_BYTES;
	localparam logic [MODE_W-1:0]      MODE_UNUSED      = 2'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 2'd3;
	localparam logic [GAP_W-1:0]       GAP_MAX          = 32'hFFFF_FFFF;
	localparam int PHASES          = 8;
	localparam int ITEMS_PER_PHASE = 48;
	localparam int SETTLE_CYCLES   = 16;
	localparam int CYCLE_LIMIT     = 1_000_000;

	// how a directed row is checked: by the predictor, by a typed queue answer, or no word at all
	typedef enum {CHK_MODEL, CHK_ANSWER, CHK_NONE} check_t;
	// handshake pressure of a phase
	typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_t;

	typedef struct {
		req_word_t w;
		check_t    chk;
		bit        acc;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	fogs_req_if req_bus();
	fogs_rsp_if rsp_bus();

	flash_op_gap_scheduler uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_bus),
		.rsp       (rsp_bus),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// queue mirror: one entry per pending request
	bit              held_is_write [QUEUE_DEPTH];
	logic [15:0]     held_page     [QUEUE_DEPTH];
	logic [31:0]     held_dst      [QUEUE_DEPTH];
	logic [31:0]     held_src      [QUEUE_DEPTH];
	int unsigned     held_len      [QUEUE_DEPTH];
	logic [7:0]      held_tag      [QUEUE_DEPTH];
	int unsigned     head_slot;
	int unsigned     held_count;

	// guard settings as last written
	logic [19:0] erase_quiet_us;
	logic [15:0] write_quiet_us;
	logic [9:0]  burst_cost_us;

	// words the block owes us, oldest first
	rsp_word_t planned_words[$];

	idle_t idle_mode;
	int    error_count = 0;
	int    request_count;
	int    tick_count;
	int    result_tally [5] = '{default: 0};
	int    cycle_count = 0;

	// clock: 10 ns period
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// every input known from time zero
	initial begin
		clk                   = 1'b0;
		arst_n                = 1'b0;
		cfg_we                = 1'b0;
		cfg_index             = '0;
		cfg_data              = '0;
		req_bus.valid         = 1'b0;
		req_bus.mode          = '0;
		req_bus.page_number   = '0;
		req_bus.flash_address = '0;
		req_bus.source_address = '0;
		req_bus.write_length  = '0;
		req_bus.request_tag   = '0;
		req_bus.gap_ticks     = '0;
		req_bus.flash_idle    = 1'b0;
	end

	function automatic rsp_word_t blank_word(input kind_t k);
		rsp_word_t r;
		r = '0;
		r.result_kind = k;
		return r;
	endfunction

	// guard of the head request in microseconds (erase guard when the queue is empty)
	function automatic logic [31:0] head_guard();
		if (held_count != 0 && held_is_write[head_slot])
			return 32'(held_len[head_slot] >> BURST_SHIFT) * 32'(burst_cost_us)
				+ 32'(write_quiet_us);
		return 32'(erase_quiet_us);
	endfunction

	// predicts the words one accepted request word causes and updates the queue mirror
	task automatic plan_flash_ops(input req_word_t w);
		rsp_word_t   r;
		logic [41:0] scaled;
		logic [33:0] us_wide;
		logic [31:0] gap_us;
		int unsigned slot;
		int unsigned pos;
		int unsigned len;
		int unsigned nbytes;
		bit          ok;
		if (w.mode == MODE_ERASE || w.mode == MODE_WRITE) begin
			ok = held_count < QUEUE_DEPTH;
			if (w.mode == MODE_WRITE && w.write_length > MAX_WRITE_BYTES)
				ok = 1'b0;
			if (ok) begin
				slot = (head_slot + held_count) % QUEUE_DEPTH;
				held_is_write[slot] = (w.mode == MODE_WRITE);
				held_page[slot]     = w.page_number;
				held_dst[slot]      = w.flash_address;
				held_src[slot]      = w.source_address;
				held_len[slot]      = 32'(w.write_length);
				held_tag[slot]      = w.request_tag;
				held_count++;
			end
			r = blank_word(KIND_QUEUE);
			r.accepted = ok;
			r.last = 1'b1;
			planned_words.push_back(r);
			return;
		end
		if (w.mode != MODE_TICK || held_count == 0)
			return;

		// ticks to microseconds, saturating at 32 bits
		scaled = {10'd0, w.gap_ticks} * 42'd625;
		us_wide = scaled[41:GAP_SHIFT];
		gap_us = (us_wide > 34'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : us_wide[31:0];
		if (!(gap_us > head_guard()) || !w.flash_idle)
			return;

		slot = head_slot;
		if (!held_is_write[slot]) begin
			r = blank_word(KIND_ERASE);
			r.erase_page = held_page[slot];
			planned_words.push_back(r);
		end else begin
			len = held_len[slot];
			pos = 0;
			while (pos < len) begin
				if (len > pos + BURST_BYTES) begin
					r = blank_word(KIND_BURST);
					nbytes = BURST_BYTES;
				end else begin
					r = blank_word(KIND_WORD);
					nbytes = (pos + WORD_BYTES < len) ? WORD_BYTES : len - pos;
				end
				r.target_address = held_dst[slot] + 32'(pos);
				r.data_address   = held_src[slot] + 32'(pos);
				r.byte_count     = COUNT_W'(nbytes);
				planned_words.push_back(r);
				pos += (r.result_kind == KIND_BURST) ? BURST_BYTES : WORD_BYTES;
			end
		end
		r = blank_word(KIND_DONE);
		r.done_tag = held_tag[slot];
		r.last = 1'b1;
		planned_words.push_back(r);
		head_slot = (slot + 1) % QUEUE_DEPTH;
		held_count--;
	endtask

	function automatic bit sender_pause();
		case (idle_mode)
			IDLE_SEND: return $urandom_range(99) < 80;
			IDLE_BOTH: return $urandom_range(99) < 31;
			default:   return 1'b0;
		endcase
	endfunction

	// receiver stalls, redrawn every cycle
	always @(posedge clk) begin
		case (idle_mode)
			IDLE_RECV: rsp_bus.ready <= $urandom_range(99) >= 80;
			IDLE_BOTH: rsp_bus.ready <= $urandom_range(99) >= 31;
			default:   rsp_bus.ready <= 1'b1;
		endcase
	end

	// drives one request word; called just after a rising edge, returns at its accepting edge
	task automatic send_word(input req_word_t w, input check_t chk, input bit typed_acc);
		int        base_size;
		rsp_word_t r;
		while (sender_pause()) begin
			req_bus.valid <= 1'b0;
			@(posedge clk);
		end
		req_bus.valid          <= 1'b1;
		req_bus.mode           <= w.mode;
		req_bus.page_number    <= w.page_number;
		req_bus.flash_address  <= w.flash_address;
		req_bus.source_address <= w.source_address;
		req_bus.write_length   <= w.write_length;
		req_bus.request_tag    <= w.request_tag;
		req_bus.gap_ticks      <= w.gap_ticks;
		req_bus.flash_idle     <= w.flash_idle;
		do
			@(posedge clk);
		while (!req_bus.ready);

		// predictor runs at the accepting edge so the queue mirror tracks the block
		base_size = planned_words.size();
		plan_flash_ops(w);
		// typed rows: the predictor still advances its state, but the table says what comes out
		if (chk != CHK_MODEL) begin
			while (planned_words.size() > base_size)
				void'(planned_words.pop_back());
			if (chk == CHK_ANSWER) begin
				r = blank_word(KIND_QUEUE);
				r.accepted = typed_acc;
				r.last = 1'b1;
				planned_words.push_back(r);
			end
		end
		if (w.mode == MODE_ERASE || w.mode == MODE_WRITE)
			request_count++;
		else if (w.mode == MODE_TICK)
			tick_count++;
	endtask

	// stop sending, let every owed word arrive, then give the sequencer time to go idle
	task automatic settle_block();
		req_bus.valid <= 1'b0;
		while (planned_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// writes all three guard registers back to back, block idle
	task automatic write_guards(input logic [19:0] erase_us, input logic [15:0] base_us,
			input logic [9:0] burst_us);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_ERASE_GUARD;
		cfg_data  <= erase_us;
		@(posedge clk);
		cfg_index <= CFG_WRITE_BASE;
		cfg_data  <= 20'(base_us);
		@(posedge clk);
		cfg_index <= CFG_BURST_TIME;
		cfg_data  <= 20'(burst_us);
		@(posedge clk);
		cfg_we <= 1'b0;
		erase_quiet_us = erase_us;
		write_quiet_us = base_us;
		burst_cost_us  = burst_us;
	endtask

	function automatic dir_row_t row(input check_t chk, input bit acc, input logic [1:0] mode,
			input logic [15:0] page, input logic [31:0] dst, input logic [31:0] src,
			input logic [15:0] len, input logic [7:0] tag, input logic [31:0] gap,
			input bit idle);
		dir_row_t d;
		d.w.mode           = mode;
		d.w.page_number    = page;
		d.w.flash_address  = dst;
		d.w.source_address = src;
		d.w.write_length   = len;
		d.w.request_tag    = tag;
		d.w.gap_ticks      = gap;
		d.w.flash_idle     = idle;
		d.chk = chk;
		d.acc = acc;
		return d;
	endfunction

	// random word: mostly well-formed request/tick traffic, with noise mixed in
	function automatic req_word_t pick_word();
		req_word_t   w;
		int unsigned roll;
		logic [63:0] thresh_ticks;
		w.mode           = MODE_TICK;
		w.page_number    = 16'($urandom);
		w.flash_address  = $urandom;
		w.source_address = $urandom;
		w.write_length   = 16'($urandom);
		w.request_tag    = 8'($urandom);
		w.gap_ticks      = $urandom;
		w.flash_idle     = $urandom_range(99) < 85;
		if ($urandom_range(99) < 3) begin
			w.mode = MODE_UNUSED;
			return w;
		end
		// fewer requests once the queue is full, so ticks drain it
		if ($urandom_range(99) < (held_count >= QUEUE_DEPTH ? 12 : 45)) begin
			w.mode = $urandom_range(1) ? MODE_WRITE : MODE_ERASE;
			roll = $urandom_range(99);
			if (roll < 65)
				w.write_length = 16'($urandom_range(64));
			else if (roll < 90)
				w.write_length = 16'($urandom_range(MAX_WRITE_BYTES, 65));
			else
				w.write_length = 16'($urandom_range(65535, MAX_WRITE_BYTES + 1));
			return w;
		end
		// gap aimed at the head guard: clear pass, right at the boundary, or anything
		thresh_ticks = (64'(head_guard()) * 64'd256) / 64'(GAP_SCALE);
		roll = $urandom_range(99);
		if (roll < 60)
			w.gap_ticks = 32'(thresh_ticks + 64'($urandom_range(4000)) + 64'd2);
		else if (roll < 80)
			w.gap_ticks = 32'(thresh_ticks + 64'($urandom_range(3)) - 64'd1);
		return w;
	endfunction

	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
			error_count++;
		end
	endtask

	// result checker: every accepted word against the oldest owed word
	always @(posedge clk) begin : result_check
		rsp_word_t got;
		rsp_word_t want;
		if (arst_n && rsp_bus.valid && rsp_bus.ready) begin
			got = {rsp_bus.result_kind, rsp_bus.accepted, rsp_bus.erase_page,
				rsp_bus.target_address, rsp_bus.data_address, rsp_bus.byte_count,
				rsp_bus.done_tag, rsp_bus.last};
			if (got.result_kind <= KIND_DONE)
				result_tally[got.result_kind]++;
			if (planned_words.size() == 0) begin
				$display("%0t: unexpected word: expected none, actual %0h", $time, got);
				error_count++;
			end else begin
				want = planned_words.pop_front();
				compare_field("result_kind", 32'(want.result_kind), 32'(got.result_kind));
				compare_field("accepted", 32'(want.accepted), 32'(got.accepted));
				compare_field("erase_page", 32'(want.erase_page), 32'(got.erase_page));
				compare_field("target_address", want.target_address, got.target_address);
				compare_field("data_address", want.data_address, got.data_address);
				compare_field("byte_count", 32'(want.byte_count), 32'(got.byte_count));
				compare_field("done_tag", 32'(want.done_tag), 32'(got.done_tag));
				compare_field("last", 32'(want.last), 32'(got.last));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin : stimulus
		dir_row_t  directed_rows[$];
		req_word_t w;
		int        counted;

		idle_mode     = IDLE_NONE;
		request_count = 0;
		tick_count    = 0;
		// predictor reset state
		head_slot      = 0;
		held_count     = 0;
		erase_quiet_us = ERASE_GUARD_RST;
		write_quiet_us = WRITE_BASE_RST;
		burst_cost_us  = BURST_TIME_RST;

		// directed table
		// tick on an empty queue, then the unused mode: both silent
		directed_rows.push_back(row(CHK_NONE, 0, MODE_TICK, 0, 0, 0, 0, 0, GAP_MAX, 1));
		directed_rows.push_back(row(CHK_NONE, 0, MODE_UNUSED, 16'hFFFF, '1, '1, '1, '1, '1, 1));
		// too long: one past the limit and the top of the field
		directed_rows.push_back(row(CHK_ANSWER, 0, MODE_WRITE, 0, 0, 0, 16'd257, 8'h11, 0, 0));
		directed_rows.push_back(row(CHK_ANSWER, 0, MODE_WRITE, '1, '1, '1, 16'hFFFF, '1, '1, 1));
		// erase at the top page; gap zero, then flash busy, then just under and over the guard
		directed_rows.push_back(row(CHK_ANSWER, 1, MODE_ERASE, 16'hFFFF, 0, 0, 0, 8'hFF, 0, 0));
		directed_rows.push_back(row(CHK_NONE, 0, MODE_TICK, 0, 0, 0, 0, 0, 32'd0, 1));
		directed_rows.push_back(row(CHK_NONE, 0, MODE_TICK, 0, 0, 0, 0, 0, GAP_MAX, 0));
		directed_rows.push_back(row(CHK_MODEL, 0, MODE_TICK, 0, 0, 0, 0, 0, 32'd8888, 1));
		directed_rows.push_back(row(CHK_MODEL, 0, MODE_TICK, 0, 0, 0, 0, 0, 32'd8889, 1));
		// zero-length write: done word only
		directed_rows.push_back(row(CHK_MODEL, 0, MODE_WRITE, 0, 0, 0, 16'd0, 8'h00, 0, 1));
		directed_rows.push_back(row(CHK_MODEL, 0, MODE_TICK, 0, 0, 0, 0, 0, GAP_MAX, 1));
		// longest write, addresses wrapping past the top
		directed_rows.push_back(row(CHK_MODEL, 0, MODE_WRITE, 0, 32'hFFFF_FFF0, 32'hFFFF_FFFF,
			16'd256, 8'h5A, 0, 1));
		directed_rows.push_back(row(CHK_MODEL, 0, MODE_TICK, 0, 0, 0, 0, 0, GAP_MAX, 1));
		// fill the queue with mixed lengths, unaligned target first
		directed_rows.push_back(row(CHK_MODEL, 0, MODE_WRITE, 0, 32'h0000_0003, 32'h1000,
			16'd1, 8'h01, 0, 1));
		directed_rows.push_back(row(CHK_MODEL, 0, MODE_WRITE, 0, 32'h0800_0000, 32'h2000,
			16'd17, 8'h02, 0, 1));
		directed_rows.push_back(row(CHK_MODEL, 0, MODE_WRITE, 0, 32'h0800_0100, 32'h3000,
			16'd6, 8'h03, 0, 1));
		directed_rows.push_back(row(CHK_MODEL, 0, MODE_ERASE, 16'h0000, 0, 0, 0, 8'h04, 0, 1));
		directed_rows.push_back(row(CHK_MODEL, 0, MODE_WRITE, 0, 32'h0800_0200, 32'h4000,
			16'd3, 8'h05, 0, 1));
		directed_rows.push_back(row(CHK_MODEL, 0, MODE_WRITE, 0, 32'h0800_0300, 32'h5000,
			16'd20, 8'h06, 0, 1));
		// seventh request while six are pending: queue full
		directed_rows.push_back(row(CHK_ANSWER, 0, MODE_ERASE, 16'h1234, 0, 0, 0, 8'h07, 0, 1));
		repeat (QUEUE_DEPTH)
			directed_rows.push_back(row(CHK_MODEL, 0, MODE_TICK, 0, 0, 0, 0, 0, GAP_MAX, 1));

		// hold reset, then release it on a rising edge
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// write to an index past the register file: must leave the guards alone
		cfg_we    <= 1'b1;
		cfg_index <= CFG_UNUSED_INDEX;
		cfg_data  <= '1;
		@(posedge clk);
		cfg_we <= 1'b0;

		foreach (directed_rows[i])
			send_word(directed_rows[i].w, directed_rows[i].chk, directed_rows[i].acc);

		// random phases: each pairs a guard setting with a handshake pattern
		for (int p = 0; p < PHASES; p++) begin
			settle_block();
			case ((p + p / 4) % 4)
				0: write_guards(20'd0, 16'd0, 10'd0);
				1: write_guards(20'hF_FFFF, 16'hFFFF, 10'h3FF);
				2: write_guards(ERASE_GUARD_RST, WRITE_BASE_RST, BURST_TIME_RST);
				default: write_guards(20'($urandom), 16'($urandom), 10'($urandom));
			endcase
			idle_mode = idle_t'(p % 4);
			counted = 0;
			while (counted < ITEMS_PER_PHASE) begin
				w = pick_word();
				send_word(w, CHK_MODEL, 1'b0);
				// ignored words do not count toward the phase
				if (w.mode != MODE_UNUSED)
					counted++;
			end
		end
		settle_block();

		$display("run covered %0d queue requests and %0d ticks over %0d guard settings",
			request_count, tick_count, PHASES + 1);
		$display("words seen: %0d answers, %0d erase, %0d burst, %0d program, %0d finished",
			result_tally[KIND_QUEUE], result_tally[KIND_ERASE], result_tally[KIND_BURST],
			result_tally[KIND_WORD], result_tally[KIND_DONE]);
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
